>>> sv/sorted_deadline_timer_queue_macros.svh
// Assertion macros for the sorted deadline timer queue.
// Used by the top level only; no other dependencies.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Implication checked every cycle, off during reset.
`define SDTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define SDTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sdtq_pkg.sv
// Package for the sorted deadline timer queue: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package sdtq_pkg;
  localparam int NumSlots = 16;
  localparam int SlotW = $clog2(NumSlots);
  localparam int LinkW = SlotW + 1;
  localparam int CntW = SlotW + 1;
  localparam logic [LinkW-1:0] NullLink = LinkW'(NumSlots);

  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0, FUNC_UPD = 3'd1, FUNC_UPD_TAGS = 3'd2,
    FUNC_REMOVE = 3'd3, FUNC_NEXT = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_BAD_ID = 2'd2, ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot_id;
    logic [63:0] deadline_ns;
    logic [31:0] callback_tag;
    logic [31:0] context_tag;
    logic [63:0] now_ns;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic [63:0] remaining_ns;
    logic [31:0] head_callback;
    logic [31:0] head_context;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_OUT_WALK, S_IN_START, S_IN_WALK, S_IN_LINK, S_NEXT, S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic out_start;
    logic out_step;
    logic in_start;
    logic in_step;
    logic in_link;
    logic do_next;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_insert;
    logic op_modify;
    logic op_next;
    logic fail;
    logic out_done;
    logic in_stop;
  } sts_t;
endpackage

>>> sv/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue, top level: ports, config, result register.
// Rejected or unknown ops end after decode; next reads the head; remove unlinks,
// insert links in order; update unlinks, then relinks; one slot a cycle per walk.
// One beat in flight; a new input is taken the cycle after the result registers.
// Reset (async, active low) empties the queue and sets active_slots to 16.
// Depends on sdtq_pkg, sdtq_ctrl, sdtq_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_deadline_timer_queue_macros.svh"
module sorted_deadline_timer_queue import sdtq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);
  logic [4:0] active_q;
  logic       out_valid_q;
  logic       busy;
  cmd_t       cmd;
  sts_t       sts;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 5'd16;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) active_q <= cfg_data_i;
      if (cmd.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  sdtq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_valid_i(out_valid_q), .out_ready_i(out_ready_i),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  sdtq_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .active_slots_i(active_q),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

  `SDTQ_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !busy)
  `SDTQ_ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, cmd.finish, out_valid_o)
  `SDTQ_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd))
endmodule

>>> sv/sdtq_ctrl.sv
// Controller state machine for the sorted deadline timer queue.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.fail) state_d = S_DONE;
        else if (sts_i.op_insert) state_d = S_IN_START;
        else if (sts_i.op_modify) state_d = S_OUT_WALK;
        else if (sts_i.op_next) state_d = S_NEXT;
        else state_d = S_DONE;
      end
      S_OUT_WALK: begin
        if (sts_i.out_done) state_d = sts_i.op_insert ? S_IN_START : S_DONE;
      end
      S_IN_START: state_d = S_IN_WALK;
      S_IN_WALK: begin
        if (sts_i.in_stop) state_d = S_IN_LINK;
      end
      S_IN_LINK: state_d = S_DONE;
      S_NEXT: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_i || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE: cmd_o.out_start = !sts_i.fail && sts_i.op_modify;
      S_OUT_WALK: cmd_o.out_step = 1'b1;
      S_IN_START: cmd_o.in_start = 1'b1;
      S_IN_WALK: cmd_o.in_step = 1'b1;
      S_IN_LINK: cmd_o.in_link = 1'b1;
      S_NEXT: cmd_o.do_next = 1'b1;
      S_DONE: cmd_o.finish = !out_valid_i || out_ready_i;
      default: ;
    endcase
  end
endmodule

>>> sv/sdtq_dp.sv
// Datapath for the sorted deadline timer queue: slot table, list walks.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps
module sdtq_dp import sdtq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic [4:0]  active_slots_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output rsp_t        rsp_o
);
  logic [NumSlots-1:0] valid_q, valid_d;
  logic [63:0]         dl_q  [NumSlots];
  logic [31:0]         cb_q  [NumSlots];
  logic [31:0]         ctx_q [NumSlots];
  logic [LinkW-1:0]    link_q [NumSlots];
  logic [LinkW-1:0]    head_q, head_d;
  req_t                req_q;
  logic [LinkW-1:0]    prev_q, prev_d, cur_q, cur_d;
  logic [CntW-1:0]     guard_q, guard_d;
  logic [SlotW-1:0]    tgt_q, tgt_d;
  logic                ins_q, ins_d;
  logic [1:0]          stat_q, stat_d;
  rsp_t                rsp_d;
  logic [CntW-1:0]     limit;
  logic [SlotW-1:0]    free_idx;
  logic                free_ok;
  logic [SlotW-1:0]    cur_s, prev_s, id_s;
  logic                cur_end, hit, id_ok;
  logic                is_ins, is_mod, dec_fail;
  logic [63:0]         diff;
  // high in the decode cycle, which follows the capture
  logic                dec_q;

  always_comb begin
    limit = (active_slots_i == '0) ? CntW'(1)
          : (32'(active_slots_i) > NumSlots) ? CntW'(NumSlots)
          : CntW'(active_slots_i);
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (CntW'(i) < limit && !valid_q[i]) begin
        free_ok = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  assign id_s     = req_q.slot_id[SlotW-1:0];
  assign id_ok    = (CntW'(req_q.slot_id) < limit) && valid_q[id_s];
  assign is_ins   = (req_q.func == FUNC_INSERT);
  assign is_mod   = (req_q.func == FUNC_UPD) || (req_q.func == FUNC_UPD_TAGS)
                 || (req_q.func == FUNC_REMOVE);
  assign dec_fail = is_ins ? !free_ok : (is_mod && !id_ok);
  assign cur_s    = cur_q[SlotW-1:0];
  assign prev_s   = prev_q[SlotW-1:0];
  assign cur_end  = (cur_q == NullLink) || (guard_q == CntW'(NumSlots));
  assign hit      = !cur_end && (cur_s == tgt_q);
  assign diff     = dl_q[head_q[SlotW-1:0]] - req_q.now_ns;

  always_comb begin
    sts_o.op_insert = ins_q;
    sts_o.op_modify = is_mod;
    sts_o.op_next = (req_q.func == FUNC_NEXT);
    sts_o.fail = dec_fail;
    sts_o.out_done = cur_end || hit;
    sts_o.in_stop = cur_end || (dl_q[tgt_q] < dl_q[cur_s]);
  end

  always_comb begin
    valid_d = valid_q; head_d = head_q; prev_d = prev_q; cur_d = cur_q;
    guard_d = guard_q; tgt_d = tgt_q; ins_d = ins_q;
    stat_d = stat_q; rsp_d = rsp_o;
    if (cmd_i.capture) begin
      ins_d = (req_i.func == FUNC_INSERT); stat_d = ST_OK;
    end
    if (dec_q) begin
      if (is_ins && free_ok) begin
        tgt_d = free_idx; valid_d[free_idx] = 1'b1;
      end else if (is_ins) begin
        stat_d = ST_FULL;
      end else if (is_mod && !id_ok) begin
        stat_d = ST_BAD_ID;
      end
    end
    if (cmd_i.out_start) begin
      prev_d = NullLink; cur_d = head_q; guard_d = '0; tgt_d = id_s;
      ins_d = (req_q.func != FUNC_REMOVE);
      if (req_q.func == FUNC_REMOVE) valid_d[id_s] = 1'b0;
    end
    if (cmd_i.out_step && !(cur_end || hit)) begin
      prev_d = cur_q; cur_d = link_q[cur_s]; guard_d = guard_q + 1'b1;
    end
    if (cmd_i.out_step && hit && prev_q == NullLink) head_d = link_q[cur_s];
    if (cmd_i.in_start) begin
      prev_d = NullLink; cur_d = head_q; guard_d = '0;
    end
    if (cmd_i.in_step && !(cur_end || (dl_q[tgt_q] < dl_q[cur_s]))) begin
      prev_d = cur_q; cur_d = link_q[cur_s]; guard_d = guard_q + 1'b1;
    end
    if (cmd_i.in_link && prev_q == NullLink) head_d = LinkW'(tgt_q);
    if (cmd_i.finish) begin
      rsp_d = '0;
      rsp_d.status = stat_q;
      if (req_q.func == FUNC_INSERT && stat_q == ST_OK) rsp_d.result_slot = 4'(tgt_q);
      if (req_q.func == FUNC_NEXT && stat_q == ST_OK) begin
        rsp_d.result_slot = 4'(head_q[SlotW-1:0]);
        rsp_d.remaining_ns = (dl_q[head_q[SlotW-1:0]] > req_q.now_ns) ? diff : '0;
        rsp_d.head_callback = cb_q[head_q[SlotW-1:0]];
        rsp_d.head_context = ctx_q[head_q[SlotW-1:0]];
      end
    end
    if (cmd_i.do_next && head_q == NullLink) stat_d = ST_EMPTY;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0; head_q <= NullLink; dec_q <= 1'b0;
      prev_q <= NullLink; cur_q <= NullLink; guard_q <= '0; tgt_q <= '0;
      ins_q <= 1'b0; stat_q <= ST_OK;
    end else begin
      valid_q <= valid_d; head_q <= head_d; prev_q <= prev_d; cur_q <= cur_d;
      guard_q <= guard_d; tgt_q <= tgt_d; ins_q <= ins_d;
      stat_q <= stat_d; dec_q <= cmd_i.capture;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    if (dec_q && is_ins && free_ok) begin
      dl_q[free_idx] <= req_q.deadline_ns;
      cb_q[free_idx] <= req_q.callback_tag;
      ctx_q[free_idx] <= req_q.context_tag;
    end
    if (cmd_i.out_start && req_q.func != FUNC_REMOVE) begin
      dl_q[id_s] <= req_q.deadline_ns;
      if (req_q.func == FUNC_UPD_TAGS) begin
        cb_q[id_s] <= req_q.callback_tag;
        ctx_q[id_s] <= req_q.context_tag;
      end
    end
    if (cmd_i.out_step && hit) begin
      if (prev_q != NullLink) link_q[prev_s] <= link_q[cur_s];
      link_q[cur_s] <= NullLink;
    end
    if (cmd_i.in_link) begin
      link_q[tgt_q] <= cur_end ? NullLink : cur_q;
      if (prev_q != NullLink) link_q[prev_s] <= LinkW'(tgt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o <= rsp_d;
  end
endmodule
